// ===== rtl/lav_pkg.sv =====
// shared constants for the look-at view matrix pipeline
// no dependencies; used by lav_unit and look_at_view_matrix
`default_nettype none
package lav_pkg;

  // width of every port field
  localparam int DATA_W = 32;
  // normalized magnitudes sit in [2^29, 2^30)
  localparam int NRM_TOP = 29;
  localparam int NRM_W = 30;
  // squares, sum of three squares and its root
  localparam int SQ_W = 60;
  localparam int SUM_W = 62;
  localparam int ROOT_W = 31;

endpackage
`default_nettype wire

// ===== rtl/lav_unit.sv =====
// pipelined vector normalizer: scale, sum of squares, digit-per-stage root,
// bit-per-stage restoring division; a sideband word travels with each item
// depends on lav_pkg
`default_nettype none
module lav_unit #(
  parameter int IN_W = 33,
  parameter int FRAC_BITS = 16,
  parameter int SB_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ce_i,
  input  logic                       valid_i,
  input  logic signed [IN_W-1:0]     vec_i [3],
  input  logic [SB_W-1:0]            sb_i,
  output logic                       valid_o,
  output logic signed [FRAC_BITS+1:0] unit_o [3],
  output logic [SB_W-1:0]            sb_o
);

  localparam int NRM_W = lav_pkg::NRM_W;
  localparam int SUM_W = lav_pkg::SUM_W;
  localparam int ROOT_W = lav_pkg::ROOT_W;
  localparam int SQ_W = lav_pkg::SQ_W;
  localparam int PW = $clog2(IN_W);
  localparam int SH_W = IN_W + lav_pkg::NRM_TOP;
  localparam int QW = FRAC_BITS + 1;
  localparam int RW = NRM_W + FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;

  // stage a: magnitudes and signs
  logic            va_q;
  logic [IN_W-1:0] ma_q [3];
  logic [2:0]      nega_q;
  logic [SB_W-1:0] sba_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ce_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < 3; i++) begin
        ma_q[i] <= vec_i[i][IN_W-1] ? IN_W'(-vec_i[i]) : IN_W'(vec_i[i]);
        nega_q[i] <= vec_i[i][IN_W-1];
      end
      sba_q <= sb_i;
    end
  end

  // stage b: leading one of the largest magnitude
  logic [IN_W-1:0] any_ones;
  logic [PW-1:0]   lead_d;
  logic            vb_q;
  logic [IN_W-1:0] mb_q [3];
  logic [2:0]      negb_q;
  logic [PW-1:0]   leadb_q;
  logic            zerob_q;
  logic [SB_W-1:0] sbb_q;

  always_comb begin
    any_ones = ma_q[0] | ma_q[1] | ma_q[2];
    lead_d = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (any_ones[i]) begin
        lead_d = PW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ce_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      mb_q <= ma_q;
      negb_q <= nega_q;
      leadb_q <= lead_d;
      zerob_q <= (any_ones == '0);
      sbb_q <= sba_q;
    end
  end

  // stage c: shift so the largest magnitude lands in [2^29, 2^30)
  logic [SH_W-1:0] wide [3];
  logic            vc_q;
  logic [NRM_W-1:0] nc_q [3];
  logic [2:0]      negc_q;
  logic            zeroc_q;
  logic [SB_W-1:0] sbc_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mb_q[i], {lav_pkg::NRM_TOP{1'b0}}} >> leadb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (ce_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < 3; i++) begin
        nc_q[i] <= wide[i][NRM_W-1:0];
      end
      negc_q <= negb_q;
      zeroc_q <= zerob_q;
      sbc_q <= sbb_q;
    end
  end

  // stage d: squares
  logic             vd_q;
  logic [SQ_W-1:0]  sqd_q [3];
  logic [NRM_W-1:0] nd_q [3];
  logic [2:0]       negd_q;
  logic             zerod_q;
  logic [SB_W-1:0]  sbd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (ce_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < 3; i++) begin
        sqd_q[i] <= SQ_W'(nc_q[i]) * SQ_W'(nc_q[i]);
      end
      nd_q <= nc_q;
      negd_q <= negc_q;
      zerod_q <= zeroc_q;
      sbd_q <= sbc_q;
    end
  end

  // square root pipeline, entry 0 holds the sum of squares
  logic             sv_q   [ROOT_W+1];
  logic [SUM_W-1:0] sx_q   [ROOT_W+1];
  logic [SUM_W-1:0] sr_q   [ROOT_W+1];
  logic [NRM_W-1:0] sn_q   [ROOT_W+1][3];
  logic [2:0]       sneg_q [ROOT_W+1];
  logic             szero_q[ROOT_W+1];
  logic [SB_W-1:0]  ssb_q  [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (ce_i) begin
      sv_q[0] <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      sx_q[0] <= SUM_W'(sqd_q[0]) + SUM_W'(sqd_q[1]) + SUM_W'(sqd_q[2]);
      sr_q[0] <= '0;
      sn_q[0] <= nd_q;
      sneg_q[0] <= negd_q;
      szero_q[0] <= zerod_q;
      ssb_q[0] <= sbd_q;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam logic [SUM_W-1:0] BITV = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SUM_W-1:0] trial;
    logic             take;

    // one result bit per stage
    always_comb begin
      trial = sr_q[k] + BITV;
      take = (sx_q[k] >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (ce_i) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        sx_q[k+1] <= take ? sx_q[k] - trial : sx_q[k];
        sr_q[k+1] <= take ? (sr_q[k] >> 1) + BITV : sr_q[k] >> 1;
        sn_q[k+1] <= sn_q[k];
        sneg_q[k+1] <= sneg_q[k];
        szero_q[k+1] <= szero_q[k];
        ssb_q[k+1] <= ssb_q[k];
      end
    end
  end

  // division pipeline, entry 0 holds rounded numerators and the length
  logic [ROOT_W-1:0] len;
  logic              dv_q   [QW+1];
  logic [RW-1:0]     dr_q   [QW+1][3];
  logic [QW-1:0]     dq_q   [QW+1][3];
  logic [ROOT_W-1:0] dl_q   [QW+1];
  logic [2:0]        dneg_q [QW+1];
  logic              dzero_q[QW+1];
  logic [SB_W-1:0]   dsb_q  [QW+1];

  assign len = sr_q[ROOT_W][ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (ce_i) begin
      dv_q[0] <= sv_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= (RW'(sn_q[ROOT_W][i]) << FRAC_BITS) + RW'(len >> 1);
        dq_q[0][i] <= '0;
      end
      dl_q[0] <= len;
      dneg_q[0] <= sneg_q[ROOT_W];
      dzero_q[0] <= szero_q[ROOT_W];
      dsb_q[0] <= ssb_q[ROOT_W];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [RW-1:0] dsr;
    logic [2:0]    take;

    // one quotient bit per stage, most significant first
    always_comb begin
      dsr = RW'(dl_q[j]) << SH;
      for (int i = 0; i < 3; i++) begin
        take[i] = (dr_q[j][i] >= dsr);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (ce_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        for (int i = 0; i < 3; i++) begin
          dr_q[j+1][i] <= take[i] ? dr_q[j][i] - dsr : dr_q[j][i];
          dq_q[j+1][i] <= {dq_q[j][i][QW-2:0], take[i]};
        end
        dl_q[j+1] <= dl_q[j];
        dneg_q[j+1] <= dneg_q[j];
        dzero_q[j+1] <= dzero_q[j];
        dsb_q[j+1] <= dsb_q[j];
      end
    end
  end

  // output stage: sign back on, zero vector stays zero
  logic signed [OW-1:0] qs [3];
  logic                 vo_q;
  logic signed [OW-1:0] uo_q [3];
  logic [SB_W-1:0]      sbo_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = {1'b0, dq_q[QW][i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (ce_i) begin
      vo_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero_q[QW]) begin
          uo_q[i] <= '0;
        end else begin
          uo_q[i] <= dneg_q[QW][i] ? -qs[i] : qs[i];
        end
      end
      sbo_q <= dsb_q[QW];
    end
  end

  assign valid_o = vo_q;
  assign unit_o = uo_q;
  assign sb_o = sbo_q;

endmodule
`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
// look-at view matrix top level: forward, side and true-up vectors plus translations
// depends on lav_pkg and lav_unit
`default_nettype none
// Takes eye, target and up (signed fixed point, FRAC_BITS fraction bits) and returns
// the twelve variable entries of the view matrix: side, true up, negated forward and the
// three saturated translations. One item per clock is accepted; the whole datapath is a
// single stall-together pipeline, so a result waiting at the output holds every stage.
// Each of the two vector normalizers spends one stage per root bit (31) and one per
// quotient bit (FRAC_BITS+1).
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lav_pkg::DATA_W-1:0]   eye_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   eye_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   eye_z_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   target_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   target_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   target_z_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   up_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   up_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0]   up_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lav_pkg::DATA_W-1:0]   side_x_o,
  output logic signed [lav_pkg::DATA_W-1:0]   side_y_o,
  output logic signed [lav_pkg::DATA_W-1:0]   side_z_o,
  output logic signed [lav_pkg::DATA_W-1:0]   trueup_x_o,
  output logic signed [lav_pkg::DATA_W-1:0]   trueup_y_o,
  output logic signed [lav_pkg::DATA_W-1:0]   trueup_z_o,
  output logic signed [lav_pkg::DATA_W-1:0]   back_x_o,
  output logic signed [lav_pkg::DATA_W-1:0]   back_y_o,
  output logic signed [lav_pkg::DATA_W-1:0]   back_z_o,
  output logic signed [lav_pkg::DATA_W-1:0]   shift_side_o,
  output logic signed [lav_pkg::DATA_W-1:0]   shift_up_o,
  output logic signed [lav_pkg::DATA_W-1:0]   shift_forward_o
);

  localparam int DW = lav_pkg::DATA_W;
  localparam int DIR_W = DW + 1;
  localparam int FW = FRAC_BITS + 2;
  localparam int PW1 = FW + DW;
  localparam int SIN_W = PW1 + 1;
  localparam int SF_W = 2 * FW;
  localparam int UR_W = SF_W + 1;
  localparam int TE_W = FW + DW;
  localparam int TS_W = TE_W + 2;
  localparam int UW = FRAC_BITS + 4;
  localparam int UE_W = UW + DW;
  localparam int DU_W = UE_W + 2;
  localparam int TW = FRAC_BITS + 38;
  localparam int SB1_W = 6 * DW;
  localparam int SB2_W = 3 * FW + 3 * DW;
  localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TW:0] SMAX = {{(TW - 30){1'b0}}, {31{1'b1}}};
  localparam logic signed [TW:0] SMIN = {{(TW - 30){1'b1}}, {31{1'b0}}};

  // round half away from zero to FRAC_BITS fraction bits
  function automatic logic signed [TW:0] rnd(input logic signed [TW-1:0] x);
    logic [TW-1:0]      m;
    logic [TW-1:0]      r;
    logic signed [TW:0] rs;
    m = x[TW-1] ? TW'(-x) : TW'(x);
    r = (m + HALF) >> FRAC_BITS;
    rs = {1'b0, r};
    rnd = x[TW-1] ? -rs : rs;
  endfunction

  // clamp to the 32-bit range
  function automatic logic [DW-1:0] sat32(input logic signed [TW:0] x);
    logic [DW-1:0] r;
    if (x > SMAX) begin
      r = {1'b0, {(DW - 1){1'b1}}};
    end else if (x < SMIN) begin
      r = {1'b1, {(DW - 1){1'b0}}};
    end else begin
      r = x[DW-1:0];
    end
    sat32 = r;
  endfunction

  // whole pipeline advances together unless the output item is stuck
  logic ce;
  logic out_v_q;
  assign ce = !out_v_q || out_ready_i;
  assign in_ready_o = ce;

  // forward direction and normalizer one
  logic signed [DIR_W-1:0] dir [3];
  logic [SB1_W-1:0]        sb1_in;
  logic                    v1;
  logic signed [FW-1:0]    f1 [3];
  logic [SB1_W-1:0]        sb1;

  assign dir[0] = DIR_W'(target_x_i) - DIR_W'(eye_x_i);
  assign dir[1] = DIR_W'(target_y_i) - DIR_W'(eye_y_i);
  assign dir[2] = DIR_W'(target_z_i) - DIR_W'(eye_z_i);
  assign sb1_in = {eye_x_i, eye_y_i, eye_z_i, up_x_i, up_y_i, up_z_i};

  lav_unit #(
    .IN_W(DIR_W),
    .FRAC_BITS(FRAC_BITS),
    .SB_W(SB1_W)
  ) u_fwd (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ce_i(ce),
    .valid_i(in_valid_i && ce),
    .vec_i(dir),
    .sb_i(sb1_in),
    .valid_o(v1),
    .unit_o(f1),
    .sb_o(sb1)
  );

  logic signed [DW-1:0] eye1 [3];
  logic signed [DW-1:0] up1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye1[i] = sb1[(5 - i) * DW +: DW];
      up1[i] = sb1[(2 - i) * DW +: DW];
    end
  end

  // f cross up products
  logic                 v2_q;
  logic signed [PW1-1:0] fu_q [6];
  logic signed [FW-1:0] f2_q [3];
  logic signed [DW-1:0] eye2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ce) begin
      v2_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      fu_q[0] <= PW1'(f1[1]) * PW1'(up1[2]);
      fu_q[1] <= PW1'(f1[2]) * PW1'(up1[1]);
      fu_q[2] <= PW1'(f1[2]) * PW1'(up1[0]);
      fu_q[3] <= PW1'(f1[0]) * PW1'(up1[2]);
      fu_q[4] <= PW1'(f1[0]) * PW1'(up1[1]);
      fu_q[5] <= PW1'(f1[1]) * PW1'(up1[0]);
      f2_q <= f1;
      eye2_q <= eye1;
    end
  end

  // side direction and normalizer two
  logic signed [SIN_W-1:0] sraw [3];
  logic [SB2_W-1:0]        sb2_in;
  logic                    v3;
  logic signed [FW-1:0]    s3 [3];
  logic [SB2_W-1:0]        sb3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sraw[i] = SIN_W'(fu_q[2 * i]) - SIN_W'(fu_q[2 * i + 1]);
    end
  end
  assign sb2_in = {f2_q[0], f2_q[1], f2_q[2], eye2_q[0], eye2_q[1], eye2_q[2]};

  lav_unit #(
    .IN_W(SIN_W),
    .FRAC_BITS(FRAC_BITS),
    .SB_W(SB2_W)
  ) u_side (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ce_i(ce),
    .valid_i(v2_q),
    .vec_i(sraw),
    .sb_i(sb2_in),
    .valid_o(v3),
    .unit_o(s3),
    .sb_o(sb3)
  );

  logic signed [FW-1:0] f3 [3];
  logic signed [DW-1:0] eye3 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f3[i] = sb3[3 * DW + (2 - i) * FW +: FW];
      eye3[i] = sb3[(2 - i) * DW +: DW];
    end
  end

  // s cross f products and translation products
  logic                   v4_q;
  logic signed [SF_W-1:0] sf_q [6];
  logic signed [TE_W-1:0] se_q [3];
  logic signed [TE_W-1:0] fe_q [3];
  logic signed [FW-1:0]   s4_q [3];
  logic signed [FW-1:0]   f4_q [3];
  logic signed [DW-1:0]   eye4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ce) begin
      v4_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sf_q[0] <= SF_W'(s3[1]) * SF_W'(f3[2]);
      sf_q[1] <= SF_W'(s3[2]) * SF_W'(f3[1]);
      sf_q[2] <= SF_W'(s3[2]) * SF_W'(f3[0]);
      sf_q[3] <= SF_W'(s3[0]) * SF_W'(f3[2]);
      sf_q[4] <= SF_W'(s3[0]) * SF_W'(f3[1]);
      sf_q[5] <= SF_W'(s3[1]) * SF_W'(f3[0]);
      for (int i = 0; i < 3; i++) begin
        se_q[i] <= TE_W'(s3[i]) * TE_W'(eye3[i]);
        fe_q[i] <= TE_W'(f3[i]) * TE_W'(eye3[i]);
      end
      s4_q <= s3;
      f4_q <= f3;
      eye4_q <= eye3;
    end
  end

  // exact u and dot product sums
  logic                   v5_q;
  logic signed [UR_W-1:0] ur5_q [3];
  logic signed [TS_W-1:0] ds5_q;
  logic signed [TS_W-1:0] df5_q;
  logic signed [FW-1:0]   s5_q [3];
  logic signed [FW-1:0]   f5_q [3];
  logic signed [DW-1:0]   eye5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (ce) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ur5_q[i] <= UR_W'(sf_q[2 * i]) - UR_W'(sf_q[2 * i + 1]);
      end
      ds5_q <= TS_W'(se_q[0]) + TS_W'(se_q[1]) + TS_W'(se_q[2]);
      df5_q <= TS_W'(fe_q[0]) + TS_W'(fe_q[1]) + TS_W'(fe_q[2]);
      s5_q <= s4_q;
      f5_q <= f4_q;
      eye5_q <= eye4_q;
    end
  end

  // round u and the side and forward translations
  logic                 v6_q;
  logic signed [UW-1:0] u6_q [3];
  logic signed [TW:0]   ts6_q;
  logic signed [TW:0]   tf6_q;
  logic signed [FW-1:0] s6_q [3];
  logic signed [FW-1:0] f6_q [3];
  logic signed [DW-1:0] eye6_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (ce) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        u6_q[i] <= UW'(rnd(TW'(ur5_q[i])));
      end
      ts6_q <= -rnd(TW'(ds5_q));
      tf6_q <= rnd(TW'(df5_q));
      s6_q <= s5_q;
      f6_q <= f5_q;
      eye6_q <= eye5_q;
    end
  end

  // u times eye products
  logic                   v7_q;
  logic signed [UE_W-1:0] ue7_q [3];
  logic signed [UW-1:0]   u7_q [3];
  logic signed [TW:0]     ts7_q;
  logic signed [TW:0]     tf7_q;
  logic signed [FW-1:0]   s7_q [3];
  logic signed [FW-1:0]   f7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (ce) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ue7_q[i] <= UE_W'(u6_q[i]) * UE_W'(eye6_q[i]);
      end
      u7_q <= u6_q;
      ts7_q <= ts6_q;
      tf7_q <= tf6_q;
      s7_q <= s6_q;
      f7_q <= f6_q;
    end
  end

  // up translation sum
  logic                   v8_q;
  logic signed [DU_W-1:0] du8_q;
  logic signed [UW-1:0]   u8_q [3];
  logic signed [TW:0]     ts8_q;
  logic signed [TW:0]     tf8_q;
  logic signed [FW-1:0]   s8_q [3];
  logic signed [FW-1:0]   f8_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (ce) begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      du8_q <= DU_W'(ue7_q[0]) + DU_W'(ue7_q[1]) + DU_W'(ue7_q[2]);
      u8_q <= u7_q;
      ts8_q <= ts7_q;
      tf8_q <= tf7_q;
      s8_q <= s7_q;
      f8_q <= f7_q;
    end
  end

  // output register
  logic signed [DW-1:0] side_q [3];
  logic signed [DW-1:0] tup_q [3];
  logic signed [DW-1:0] back_q [3];
  logic signed [DW-1:0] sh_side_q;
  logic signed [DW-1:0] sh_up_q;
  logic signed [DW-1:0] sh_fwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ce) begin
      out_v_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        side_q[i] <= DW'(s8_q[i]);
        tup_q[i] <= DW'(u8_q[i]);
        back_q[i] <= -DW'(f8_q[i]);
      end
      sh_side_q <= sat32(ts8_q);
      sh_up_q <= sat32(-rnd(TW'(du8_q)));
      sh_fwd_q <= sat32(tf8_q);
    end
  end

  assign out_valid_o = out_v_q;
  assign side_x_o = side_q[0];
  assign side_y_o = side_q[1];
  assign side_z_o = side_q[2];
  assign trueup_x_o = tup_q[0];
  assign trueup_y_o = tup_q[1];
  assign trueup_z_o = tup_q[2];
  assign back_x_o = back_q[0];
  assign back_y_o = back_q[1];
  assign back_z_o = back_q[2];
  assign shift_side_o = sh_side_q;
  assign shift_up_o = sh_up_q;
  assign shift_forward_o = sh_fwd_q;

  // a zero side vector forces true up and both side-derived translations to zero
  a_zero_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && side_x_o == '0 && side_y_o == '0 && side_z_o == '0) |->
    (trueup_x_o == '0 && trueup_y_o == '0 && trueup_z_o == '0 &&
     shift_side_o == '0 && shift_up_o == '0))
    else $error("true up or side translation nonzero with zero side vector");

  // back x, back z and side y components never exceed one in magnitude
  a_back_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (back_x_o <= (32'sd1 <<< FRAC_BITS) &&
                     back_x_o >= -(32'sd1 <<< FRAC_BITS) &&
                     back_z_o <= (32'sd1 <<< FRAC_BITS) &&
                     back_z_o >= -(32'sd1 <<< FRAC_BITS)))
    else $error("forward component outside unit range");

  a_side_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (side_y_o <= (32'sd1 <<< FRAC_BITS) &&
                     side_y_o >= -(32'sd1 <<< FRAC_BITS)))
    else $error("side component outside unit range");

endmodule
`default_nettype wire
